/* hw/rtl/fixed_capacity_multiset_table_top_macros.svh */
// assertion helpers for the top-level rtl file
`ifndef FIXED_CAPACITY_MULTISET_TABLE_TOP_MACROS_SVH
`define FIXED_CAPACITY_MULTISET_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define FCMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FCMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fcmt_pkg.sv */
`timescale 1ns / 1ps

package fcmt_pkg;

    typedef logic [2:0] func_t;

    localparam func_t FUNC_ADD       = 3'd0;
    localparam func_t FUNC_REMOVE    = 3'd1;
    localparam func_t FUNC_CONTAINS  = 3'd2;
    localparam func_t FUNC_FREQUENCY = 3'd3;
    localparam func_t FUNC_CLEAR     = 3'd4;

    localparam int RESULT_BITS = 5;

endpackage

/* hw/rtl/fcmt_mem.sv */
`timescale 1ns / 1ps

module fcmt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/fixed_capacity_multiset_table_top.sv */
`timescale 1ns / 1ps
// channel  | signals                                   | dir
// ---------+-------------------------------------------+-----
// request  | in_valid, in_ready, func, entry           | in
// result   | out_valid, out_ready, ok, match_count,    | out
//          | size_now, is_empty                        |
//
// one request at a time; add, clear and unknown codes pass through the exec
// and resp states from accept to result, remove/contains/frequency scan the
// entry memory one word a cycle, set by the single read port of the memory,
// before resp (remove adds the move_rd and move_wr states for the last entry)
// reset empties the bag at once; memory contents are not cleared
// a stalled result sits in the output register while the next request is taken

module fixed_capacity_multiset_table_top #(
    parameter int CAPACITY   = 16,
    parameter int ENTRY_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fcmt_pkg::func_t     func,
    input  logic [31:0]         entry,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic [4:0]          match_count,
    output logic [4:0]          size_now,
    output logic                is_empty
);

    `include "fixed_capacity_multiset_table_top_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = (CW > fcmt_pkg::RESULT_BITS) ? CW : fcmt_pkg::RESULT_BITS;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_MOVE_RD = 3'd3;
    localparam logic [2:0] S_MOVE_WR = 3'd4;
    localparam logic [2:0] S_RESP    = 3'd5;

    logic [ENTRY_BITS-1:0] value_in;

    generate
        if (ENTRY_BITS <= 32)
        begin : g_narrow
            assign value_in = entry[ENTRY_BITS-1:0];
        end
        else
        begin : g_wide
            assign value_in = {{(ENTRY_BITS-32){1'b0}}, entry};
        end
    endgenerate

    logic [2:0]            state_reg, state_next;
    fcmt_pkg::func_t       func_reg, func_next;
    logic [ENTRY_BITS-1:0] value_reg, value_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic [AW-1:0]         at_reg, at_next;
    logic [CW-1:0]         hits_reg, hits_next;
    logic                  ok_reg, ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  ok_out_reg, ok_out_next;
    logic [4:0]            match_out_reg, match_out_next;
    logic [4:0]            size_out_reg, size_out_next;
    logic                  empty_out_reg, empty_out_next;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [ENTRY_BITS-1:0] rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;

    logic                  hit;
    logic [CW-1:0]         count_m1;
    logic [OW-1:0]         hits_ext;
    logic [OW-1:0]         count_ext;

    fcmt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign hit       = pend_reg && (rd_data == value_reg);
    assign count_m1  = count_reg - CW'(1);
    assign hits_ext  = OW'(hits_reg);
    assign count_ext = OW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        at_next        = at_reg;
        hits_next      = hits_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        ok_out_next    = ok_out_reg;
        match_out_next = match_out_reg;
        size_out_next  = size_out_reg;
        empty_out_next = empty_out_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = value_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    value_next = value_in;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    hits_next  = '0;
                    ok_next    = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (func_reg) inside
                    fcmt_pkg::FUNC_ADD:
                    begin
                        if (count_reg < CW'(CAPACITY))
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    fcmt_pkg::FUNC_CLEAR:
                    begin
                        count_next = '0;
                        ok_next    = 1'b1;
                        state_next = S_RESP;
                    end
                    fcmt_pkg::FUNC_REMOVE, fcmt_pkg::FUNC_CONTAINS,
                    fcmt_pkg::FUNC_FREQUENCY:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN:
            begin
                // rd_data holds the word read last cycle when pend_reg is set
                if (hit && (func_reg != fcmt_pkg::FUNC_FREQUENCY))
                begin
                    pend_next = 1'b0;
                    at_next   = pend_idx_reg;
                    if (func_reg == fcmt_pkg::FUNC_REMOVE)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    hits_next = hits_reg + CW'(hit);
                    if (ptr_reg == count_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = ptr_reg[AW-1:0];
                        pend_idx_next = ptr_reg[AW-1:0];
                        pend_next     = 1'b1;
                        ptr_next      = ptr_reg + CW'(1);
                    end
                end
            end
            S_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = count_m1[AW-1:0];
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                // last entry fills the hole; harmless when it is the hole itself
                wr_en      = 1'b1;
                wr_addr    = at_reg;
                wr_data    = rd_data;
                count_next = count_m1;
                ok_next    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_out_next    = ok_reg;
                    match_out_next = hits_ext[4:0];
                    size_out_next  = count_ext[4:0];
                    empty_out_next = (count_reg == '0);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        value_reg     <= value_next;
        ptr_reg       <= ptr_next;
        pend_idx_reg  <= pend_idx_next;
        at_reg        <= at_next;
        hits_reg      <= hits_next;
        ok_reg        <= ok_next;
        ok_out_reg    <= ok_out_next;
        match_out_reg <= match_out_next;
        size_out_reg  <= size_out_next;
        empty_out_reg <= empty_out_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = ok_out_reg;
    assign match_count = match_out_reg;
    assign size_now    = size_out_reg;
    assign is_empty    = empty_out_reg;

    `FCMT_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CW'(CAPACITY), "bag count above capacity")
    `FCMT_ASSERT_NOW(a_move_not_empty, state_reg == S_MOVE_WR, count_reg != '0, "remove move with empty bag")
    `FCMT_ASSERT_NOW(a_pend_in_bag, pend_reg, {1'b0, pend_idx_reg} < (AW+1)'(count_reg), "scan read beyond stored entries")
    `FCMT_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == S_EXEC, "accepted request not executed")
    `FCMT_ASSERT_NEXT(a_resp_loads, state_reg == S_RESP && (!out_valid_reg || out_ready), out_valid_reg && state_reg == S_IDLE, "result not loaded")

endmodule

/* dv/tb_fixed_capacity_multiset_table_top.sv */
`timescale 1ns / 1ps

module tb_fixed_capacity_multiset_table_top;

    localparam int CAPACITY     = 16;
    localparam int ENTRY_BITS   = 32;
    localparam int POOL_SIZE    = 6;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 17;
    localparam int DRAIN_CYCLES = 40;

    // codes the block must treat as no-ops
    localparam fcmt_pkg::func_t FUNC_RSVD_FIRST = 3'd5;
    localparam fcmt_pkg::func_t FUNC_RSVD_MID   = 3'd6;
    localparam fcmt_pkg::func_t FUNC_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic       ok;
        logic [4:0] match_count;
        logic [4:0] size_now;
        logic       is_empty;
    } bag_result_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    fcmt_pkg::func_t func;
    logic [31:0]     entry;
    logic            out_valid;
    logic            out_ready;
    logic            ok;
    logic [4:0]      match_count;
    logic [4:0]      size_now;
    logic            is_empty;

    // predicted bag contents
    logic [ENTRY_BITS-1:0] bag_entries [CAPACITY];
    int                    bag_size;

    bag_result_t           pending_results [$];
    logic [31:0]           value_pool [POOL_SIZE];
    int                    failures;
    bit                    no_idle;
    int                    hold_off_cycles;

    fixed_capacity_multiset_table_top #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .entry       (entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .match_count (match_count),
        .size_now    (size_now),
        .is_empty    (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic bag_result_t apply_request(fcmt_pkg::func_t f, logic [31:0] e);
        bag_result_t           res;
        logic [ENTRY_BITS-1:0] key;
        int                    hit_at;
        int                    hits;
        res    = '0;
        key    = e[ENTRY_BITS-1:0];
        hit_at = -1;
        hits   = 0;
        for (int i = 0; i < bag_size; i++)
        begin
            if (bag_entries[i] == key)
            begin
                hits++;
                if (hit_at < 0)
                    hit_at = i;
            end
        end
        case (f)
            fcmt_pkg::FUNC_ADD:
            begin
                if (bag_size < CAPACITY)
                begin
                    bag_entries[bag_size] = key;
                    bag_size++;
                    res.ok = 1'b1;
                end
            end
            fcmt_pkg::FUNC_REMOVE:
            begin
                if (hit_at >= 0)
                begin
                    // last entry fills the hole
                    bag_size--;
                    bag_entries[hit_at] = bag_entries[bag_size];
                    res.ok = 1'b1;
                end
            end
            fcmt_pkg::FUNC_CONTAINS:  res.ok = (hit_at >= 0);
            fcmt_pkg::FUNC_FREQUENCY: res.match_count = hits[4:0];
            fcmt_pkg::FUNC_CLEAR:
            begin
                bag_size = 0;
                res.ok   = 1'b1;
            end
            default: ;
        endcase
        res.size_now = bag_size[4:0];
        res.is_empty = (bag_size == 0);
        return res;
    endfunction

    task automatic send_request(fcmt_pkg::func_t f, logic [31:0] e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        func     = f;
        entry    = e;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results = {pending_results, apply_request(f, e)};
    endtask

    task automatic wait_for_results();
        // withdraw the last request so it is not taken twice
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, int exp_val, int act_val, logic act_bits_known);
        if (!act_bits_known || exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            failures++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (hold_off_cycles != 0)
            begin
                out_ready = 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            else if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!(out_valid === 1'b1));
        end
    end

    // compare every result transaction with the oldest prediction
    initial
    begin
        bag_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no request pending");
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("ok", int'(want.ok), int'(ok), !$isunknown(ok));
                    check_field("match_count", int'(want.match_count), int'(match_count),
                                !$isunknown(match_count));
                    check_field("size_now", int'(want.size_now), int'(size_now),
                                !$isunknown(size_now));
                    check_field("is_empty", int'(want.is_empty), int'(is_empty),
                                !$isunknown(is_empty));
                end
            end
        end
    end

    function automatic fcmt_pkg::func_t pick_func(int add_weight);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < add_weight)
            return fcmt_pkg::FUNC_ADD;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return fcmt_pkg::FUNC_REMOVE;
        if (roll < 60)
            return fcmt_pkg::FUNC_CONTAINS;
        if (roll < 85)
            return fcmt_pkg::FUNC_FREQUENCY;
        if (roll < 91)
            return fcmt_pkg::FUNC_CLEAR;
        return fcmt_pkg::func_t'($urandom_range(FUNC_RSVD_LAST, FUNC_RSVD_FIRST));
    endfunction

    // mostly pool values so that matches and duplicates are common
    function automatic logic [31:0] pick_entry();
        if ($urandom_range(0, 9) < 8)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();
        value_pool[0] = '0;
        value_pool[1] = '1;
    endtask

    task automatic test_empty_bag();
        send_request(fcmt_pkg::FUNC_REMOVE, 32'h0000_0000);
        send_request(fcmt_pkg::FUNC_FREQUENCY, 32'hffff_ffff);
        send_request(FUNC_RSVD_FIRST, 32'h1234_5678);
        wait_for_results();
    endtask

    task automatic test_fill_and_drain();
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (i % 4)
                0: send_request(fcmt_pkg::FUNC_ADD, 32'h0000_0000);
                1: send_request(fcmt_pkg::FUNC_ADD, 32'hffff_ffff);
                2: send_request(fcmt_pkg::FUNC_ADD, 32'h1 << i);
                default: send_request(fcmt_pkg::FUNC_ADD, ~(32'h1 << (31 - i)));
            endcase
        end
        // no room left
        send_request(fcmt_pkg::FUNC_ADD, 32'hdead_beef);
        send_request(fcmt_pkg::FUNC_FREQUENCY, 32'h0000_0000);
        send_request(fcmt_pkg::FUNC_CONTAINS, 32'h0000_0004);
        send_request(fcmt_pkg::FUNC_REMOVE, 32'hffff_ffff);
        send_request(fcmt_pkg::FUNC_REMOVE, 32'hdead_beef);
        send_request(FUNC_RSVD_LAST, 32'hffff_ffff);
        send_request(fcmt_pkg::FUNC_CLEAR, 32'h5555_aaaa);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int add_weight;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            refresh_pool();
            no_idle    = ($urandom_range(0, 3) == 0);
            add_weight = $urandom_range(15, 60);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(pick_func(add_weight), pick_entry());
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        refresh_pool();
        no_idle         = 1'b1;
        hold_off_cycles = 80;
        for (int i = 0; i < 20; i++)
            send_request(i < 8 ? fcmt_pkg::FUNC_ADD : pick_func(30), pick_entry());
        no_idle = 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        func            = fcmt_pkg::FUNC_ADD;
        entry           = '0;
        failures        = 0;
        no_idle         = 1'b0;
        hold_off_cycles = 0;
        bag_size        = 0;
        for (int i = 0; i < CAPACITY; i++)
            bag_entries[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_bag();
        test_fill_and_drain();
        test_result_backpressure();
        test_random_traffic();

        @(negedge clk);
        in_valid = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
